[src/ldct_pkg.sv]
// ============================================================================
// ldct_pkg : shared types, constants and micro-op table
// Word widths, the lifting micro-op encoding and the per-step program of the
// shared 1-D lifting unit for the 4x4 forward/inverse transform.
// ============================================================================
package ldct_pkg;

  localparam int IN_W      = 20;   // field width of input columns
  localparam int OUT_W     = 20;
  localparam int WORD_W    = 30;   // internal word, covers two passes of growth
  localparam int COEF_W    = 16;
  localparam int PROD_W    = WORD_W + COEF_W;
  localparam int STEP_W    = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = 4'd12;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t vec_t [4];

  typedef enum logic [1:0] {
    OP_NOP,
    OP_ADD,
    OP_SUB,
    OP_MUL
  } op_t;

  // operand / destination selects inside the lifting unit
  typedef enum logic [2:0] {
    R_W0,
    R_W1,
    R_W2,
    R_W3,
    R_H,
    R_ZERO
  } reg_sel_t;

  // second operand shaping: plain, halved toward zero, rounded product
  typedef enum logic [1:0] {
    X_B,
    X_HALF,
    X_PROD
  } xsel_t;

  typedef enum logic [1:0] {
    C_23013,
    C_21407,
    C_18293
  } coef_t;

  typedef struct packed {
    op_t      op;
    xsel_t    xsel;
    reg_sel_t dst;
    reg_sel_t a;
    reg_sel_t b;
    coef_t    coef;
  } uop_t;

  typedef struct packed {
    logic start;
    logic inverse;
  } lift_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lift_sts_t;

  function automatic logic signed [COEF_W-1:0] coef_value(coef_t c);
    logic signed [COEF_W-1:0] v;
    unique case (c)
      C_23013: v = 16'sd23013;
      C_21407: v = 16'sd21407;
      C_18293: v = 16'sd18293;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic uop_t mk_uop(op_t op, xsel_t xs, reg_sel_t dst, reg_sel_t a,
                                  reg_sel_t b, coef_t c);
    uop_t u;
    u.op   = op;
    u.xsel = xs;
    u.dst  = dst;
    u.a    = a;
    u.b    = b;
    u.coef = c;
    return u;
  endfunction

  // Lifting program. Forward: w0..w3 = t0..t3 with t1/t2 swapped on load.
  // Inverse: w0..w3 = t0..t3, w1/w2 swapped on unload.
  function automatic uop_t lift_uop(logic inv, logic [STEP_W-1:0] step);
    uop_t u;
    u = mk_uop(OP_NOP, X_B, R_ZERO, R_ZERO, R_ZERO, C_23013);
    if (!inv) begin
      unique case (step)
        4'd0:    u = mk_uop(OP_SUB, X_B,    R_W3, R_W0,   R_W3,   C_23013);
        4'd1:    u = mk_uop(OP_ADD, X_B,    R_W2, R_W2,   R_W1,   C_23013);
        4'd2:    u = mk_uop(OP_ADD, X_HALF, R_H,  R_ZERO, R_W2,   C_23013);
        4'd3:    u = mk_uop(OP_SUB, X_B,    R_W1, R_H,    R_W1,   C_23013);
        4'd4:    u = mk_uop(OP_SUB, X_HALF, R_W0, R_W0,   R_W3,   C_23013);
        4'd5:    u = mk_uop(OP_ADD, X_B,    R_W0, R_W0,   R_H,    C_23013);
        4'd6:    u = mk_uop(OP_SUB, X_B,    R_W2, R_W0,   R_W2,   C_23013);
        4'd7:    u = mk_uop(OP_MUL, X_B,    R_ZERO, R_ZERO, R_W1, C_23013);
        4'd8:    u = mk_uop(OP_SUB, X_PROD, R_W3, R_W3,   R_ZERO, C_23013);
        4'd9:    u = mk_uop(OP_MUL, X_B,    R_ZERO, R_ZERO, R_W3, C_21407);
        4'd10:   u = mk_uop(OP_ADD, X_PROD, R_W1, R_W1,   R_ZERO, C_21407);
        4'd11:   u = mk_uop(OP_MUL, X_B,    R_ZERO, R_ZERO, R_W1, C_18293);
        4'd12:   u = mk_uop(OP_SUB, X_PROD, R_W3, R_W3,   R_ZERO, C_18293);
        default: u = mk_uop(OP_NOP, X_B,    R_ZERO, R_ZERO, R_ZERO, C_23013);
      endcase
    end else begin
      unique case (step)
        4'd0:    u = mk_uop(OP_MUL, X_B,    R_ZERO, R_ZERO, R_W1, C_18293);
        4'd1:    u = mk_uop(OP_ADD, X_PROD, R_W3, R_W3,   R_ZERO, C_18293);
        4'd2:    u = mk_uop(OP_MUL, X_B,    R_ZERO, R_ZERO, R_W3, C_21407);
        4'd3:    u = mk_uop(OP_SUB, X_PROD, R_W1, R_W1,   R_ZERO, C_21407);
        4'd4:    u = mk_uop(OP_MUL, X_B,    R_ZERO, R_ZERO, R_W1, C_23013);
        4'd5:    u = mk_uop(OP_ADD, X_PROD, R_W3, R_W3,   R_ZERO, C_23013);
        4'd6:    u = mk_uop(OP_SUB, X_B,    R_W2, R_W0,   R_W2,   C_23013);
        4'd7:    u = mk_uop(OP_ADD, X_HALF, R_H,  R_ZERO, R_W2,   C_23013);
        4'd8:    u = mk_uop(OP_SUB, X_B,    R_W0, R_W0,   R_H,    C_23013);
        4'd9:    u = mk_uop(OP_ADD, X_HALF, R_W0, R_W0,   R_W3,   C_23013);
        4'd10:   u = mk_uop(OP_SUB, X_B,    R_W1, R_H,    R_W1,   C_23013);
        4'd11:   u = mk_uop(OP_SUB, X_B,    R_W2, R_W2,   R_W1,   C_23013);
        4'd12:   u = mk_uop(OP_SUB, X_B,    R_W3, R_W0,   R_W3,   C_23013);
        default: u = mk_uop(OP_NOP, X_B,    R_ZERO, R_ZERO, R_ZERO, C_23013);
      endcase
    end
    return u;
  endfunction

endpackage

[src/ldct_if.sv]
// ============================================================================
// ldct_if : valid/ready channels of the 4x4 lifting transform
// Row input, row result and direction write channels.
// ============================================================================
interface ldct_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ldct_pkg::IN_W-1:0]        in_0;
  logic signed [ldct_pkg::IN_W-1:0]        in_1;
  logic signed [ldct_pkg::IN_W-1:0]        in_2;
  logic signed [ldct_pkg::IN_W-1:0]        in_3;

  modport source (output valid, in_0, in_1, in_2, in_3, input ready);
  modport sink   (input valid, in_0, in_1, in_2, in_3, output ready);
endinterface

interface ldct_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ldct_pkg::OUT_W-1:0]       out_0;
  logic signed [ldct_pkg::OUT_W-1:0]       out_1;
  logic signed [ldct_pkg::OUT_W-1:0]       out_2;
  logic signed [ldct_pkg::OUT_W-1:0]       out_3;
  logic [1:0]                              out_row;
  logic                                    last_row;

  modport source (output valid, out_0, out_1, out_2, out_3, out_row, last_row,
                  input ready);
  modport sink   (input valid, out_0, out_1, out_2, out_3, out_row, last_row,
                  output ready);
endinterface

interface ldct_cfg_if;
  logic valid;
  logic ready;
  logic direction;

  modport source (output valid, direction, input ready);
  modport sink   (input valid, direction, output ready);
endinterface

[src/ldct_lift.sv]
// ============================================================================
// ldct_lift : shared 1-D lifting unit
// Runs the 13-step forward or inverse lifting program on one 4-vector with a
// single add/subtract stage for the steps and a single registered multiplier.
// ============================================================================
module ldct_lift (
  input  logic               clk,
  input  logic               rst_n,
  input  ldct_pkg::lift_ctl_t ctl,
  input  ldct_pkg::vec_t     vin,
  output ldct_pkg::lift_sts_t sts,
  output ldct_pkg::vec_t     vout
);
  import ldct_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic              inv_r;

  word_t                     w0_r, w1_r, w2_r, w3_r, h_r;
  logic signed [PROD_W-1:0]  p_r;
  coef_t                     coef_r;

  uop_t                      uop;
  word_t                     a_val, b_val, half_b, x_val, res;
  word_t                     bsum;
  logic signed [PROD_W-1:0]  rsum, rsh, prod_nxt;
  logic                      go;

  assign go  = ctl.start && !busy_r;
  assign uop = lift_uop(inv_r, step_r);

  always_comb begin
    unique case (uop.a)
      R_W0:    a_val = w0_r;
      R_W1:    a_val = w1_r;
      R_W2:    a_val = w2_r;
      R_W3:    a_val = w3_r;
      R_H:     a_val = h_r;
      default: a_val = '0;
    endcase
    unique case (uop.b)
      R_W0:    b_val = w0_r;
      R_W1:    b_val = w1_r;
      R_W2:    b_val = w2_r;
      R_W3:    b_val = w3_r;
      R_H:     b_val = h_r;
      default: b_val = '0;
    endcase
  end

  // halve toward zero: bias negatives by one, then shift
  always_comb begin
    bsum   = b_val + $signed({{(WORD_W-1){1'b0}}, b_val[WORD_W-1]});
    half_b = bsum >>> 1;
  end

  // rounded product term (p + off) >> s
  always_comb begin
    if (coef_r == C_18293) begin
      rsum = p_r + 46'sd8192;
      rsh  = rsum >>> 14;
    end else begin
      rsum = p_r + 46'sd16384;
      rsh  = rsum >>> 15;
    end
  end

  assign prod_nxt = PROD_W'(b_val) * PROD_W'(coef_value(uop.coef));

  always_comb begin
    case (uop.xsel)
      X_HALF:  x_val = half_b;
      X_PROD:  x_val = rsh[WORD_W-1:0];
      default: x_val = b_val;
    endcase
    res = (uop.op == OP_SUB) ? a_val - x_val : a_val + x_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      inv_r <= ctl.inverse;
      w0_r  <= vin[0];
      w1_r  <= ctl.inverse ? vin[1] : vin[2];
      w2_r  <= ctl.inverse ? vin[2] : vin[1];
      w3_r  <= vin[3];
    end else if (busy_r) begin
      case (uop.op)
        OP_MUL: begin
          p_r    <= prod_nxt;
          coef_r <= uop.coef;
        end
        OP_ADD, OP_SUB: begin
          unique case (uop.dst)
            R_W0:    w0_r <= res;
            R_W1:    w1_r <= res;
            R_W2:    w2_r <= res;
            R_W3:    w3_r <= res;
            R_H:     h_r  <= res;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign vout[0]  = w0_r;
  assign vout[1]  = inv_r ? w2_r : w1_r;
  assign vout[2]  = inv_r ? w1_r : w2_r;
  assign vout[3]  = w3_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("lift done held longer than one cycle");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("lift start while busy");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r == LAST_STEP && !ctl.start) |=> (done_r && !busy_r))
    else $error("lift program did not finish after last step");

endmodule

[src/lifting_dct_4x4_fwd_inv.sv]
// ============================================================================
// lifting_dct_4x4_fwd_inv : 4x4 reversible integer lifting DCT, fwd/inv
// Collects four rows, runs two 1-D lifting passes on a shared unit and
// returns four saturated result rows.
// ============================================================================
// A block arrives as four row transactions; the first three return nothing.
// The fourth row starts the transform in the direction held in the direction
// register at that moment (0 forward: columns then rows; 1 inverse: rows then
// columns). One shared lifting unit processes the eight 1-D vectors in turn,
// each as an issue, the 13 program steps and a write-back; the four result
// rows then leave one per cycle when the sink is ready, row 3 flagged by
// last_row. The block takes no new row while it computes or emits. Results
// saturate to COEFF_WIDTH bits and are carried in the 20-bit fields as their
// low bits.
module lifting_dct_4x4_fwd_inv #(
  parameter int COEFF_WIDTH = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  ldct_cfg_if.sink    cfg_ch,
  ldct_in_if.sink     in_ch,
  ldct_out_if.source  out_ch
);
  import ldct_pkg::*;

  localparam int SAT_W = 33;
  localparam logic signed [SAT_W-1:0] SAT_HI = (33'sd1 <<< (COEFF_WIDTH - 1)) - 33'sd1;
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - 33'sd1;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t     state_r;
  logic [1:0] cnt_r;      // rows loaded, then rows emitted
  logic [2:0] pass_r;     // 1-D vector index, 0..7
  logic       inv_r;      // direction latched with the fourth row
  logic       dir_r;      // direction register

  word_t      blk_r [4][4];

  lift_ctl_t  ctl;
  lift_sts_t  sts;
  vec_t       vin, vout;

  logic       in_acc, out_acc, col_mode, wb;

  function automatic logic signed [OUT_W-1:0] sat_out(word_t v);
    logic signed [SAT_W-1:0] ve;
    ve = SAT_W'(v);
    if (ve > SAT_HI) ve = SAT_HI;
    else if (ve < SAT_LO) ve = SAT_LO;
    return ve[OUT_W-1:0];
  endfunction

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign wb      = (state_r == ST_WAIT) && sts.done;

  // forward does columns first, inverse rows first
  assign col_mode = pass_r[2] ~^ inv_r;

  // the next vector is always column 0 or row 0; write-back rotates the block
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vin[i] = col_mode ? blk_r[i][0] : blk_r[0][i];
    end
  end

  assign ctl.start   = (state_r == ST_ISSUE);
  assign ctl.inverse = inv_r;

  ldct_lift u_lift (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .vin   (vin),
    .sts   (sts),
    .vout  (vout)
  );

  // direction register: always ready; the user writes it between blocks, the block does not enforce this
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      dir_r <= cfg_ch.direction;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      pass_r  <= '0;
      inv_r   <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == 2'd3) begin
              state_r <= ST_ISSUE;
              pass_r  <= '0;
              inv_r   <= dir_r;
            end
          end
        end
        ST_ISSUE: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (sts.done) begin
            pass_r <= pass_r + 1'b1;
            state_r <= (pass_r == 3'd7) ? ST_OUT : ST_ISSUE;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == 2'd3) state_r <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  // block store: rows shift up on load and emit; vectors rotate on write-back
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) blk_r[r][c] <= blk_r[r+1][c];
      end
      blk_r[3][0] <= WORD_W'(in_ch.in_0);
      blk_r[3][1] <= WORD_W'(in_ch.in_1);
      blk_r[3][2] <= WORD_W'(in_ch.in_2);
      blk_r[3][3] <= WORD_W'(in_ch.in_3);
    end else if (wb) begin
      if (col_mode) begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 3; c++) blk_r[r][c] <= blk_r[r][c+1];
          blk_r[r][3] <= vout[r];
        end
      end else begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 4; c++) blk_r[r][c] <= blk_r[r+1][c];
        end
        for (int c = 0; c < 4; c++) blk_r[3][c] <= vout[c];
      end
    end else if (out_acc) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) blk_r[r][c] <= blk_r[r+1][c];
      end
    end
  end

  assign in_ch.ready     = (state_r == ST_LOAD);
  assign out_ch.valid    = (state_r == ST_OUT);
  assign out_ch.out_0    = sat_out(blk_r[0][0]);
  assign out_ch.out_1    = sat_out(blk_r[0][1]);
  assign out_ch.out_2    = sat_out(blk_r[0][2]);
  assign out_ch.out_3    = sat_out(blk_r[0][3]);
  assign out_ch.out_row  = cnt_r;
  assign out_ch.last_row = (cnt_r == 2'd3);

  a_fourth_row: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cnt_r == 2'd3) |=> (state_r == ST_ISSUE && pass_r == 3'd0))
    else $error("fourth row did not start the transform");

  a_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (wb && pass_r == 3'd7) |=> (out_ch.valid && cnt_r == 2'd0))
    else $error("eighth vector did not start the result rows");

  a_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE) |-> !sts.busy)
    else $error("vector issued to a busy lifting unit");

  a_last_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.last_row) |=> (in_ch.ready && cnt_r == 2'd0))
    else $error("block not ready for rows after last result row");

endmodule
